// ===== rtl/lpfc_pkg.sv =====
// Package for the LRU page fault counter: widths, register indexes, shared types.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
package lpfc_pkg;
  localparam int unsigned FRAMES   = 16;
  localparam int unsigned FIDX_W   = $clog2(FRAMES);
  localparam int unsigned FCNT_W   = $clog2(FRAMES + 1);
  localparam int unsigned ADDR_W   = 31;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned DIV_STEPS = ADDR_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);
  localparam int unsigned QDEPTH   = 2;

  // Register indexes on the configuration port
  localparam logic REG_NUM_FRAMES = 1'b0;
  localparam logic REG_PAGE_BYTES = 1'b1;

  localparam logic [4:0]        NUM_FRAMES_RST = 5'd16;
  localparam logic [ADDR_W-1:0] PAGE_BYTES_RST = ADDR_W'(4096);

  // A page number word with its valid flag
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] page;
  } lpfc_page_t;

  // One finished result word
  typedef struct packed {
    logic               fault;
    logic [FIDX_W-1:0]  frame;
    logic [ADDR_W-1:0]  page;
    logic [TOTAL_W-1:0] total;
  } lpfc_res_t;
endpackage

// ===== rtl/lpfc_div.sv =====
// Front end: takes an address word and divides it by the page size, one
// quotient bit per cycle (restoring division). Depends on lpfc_pkg.
`timescale 1ns / 1ps
module lpfc_div import lpfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [ADDR_W-1:0] page_bytes_i,
  output logic              busy_o,
  output lpfc_page_t        out_o,
  input  logic              out_ack_i
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_HOLD = 3'b100
  } fstate_e;

  fstate_e             state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [ADDR_W-1:0]   dvd_q, dvd_d;
  logic [ADDR_W-1:0]   dvs_q, dvs_d;
  logic [ADDR_W:0]     rem_q, rem_d;
  logic [ADDR_W:0]     rem_sh;
  logic                ge;

  // One restoring step
  assign rem_sh = {rem_q[ADDR_W-1:0], dvd_q[ADDR_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          dvd_d   = addr_i;
          // zero page size divides as one
          dvs_d   = (page_bytes_i == '0) ? ADDR_W'(1) : page_bytes_i;
          rem_d   = '0;
          step_d  = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        dvd_d  = {dvd_q[ADDR_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = F_HOLD;
      end
      F_HOLD: begin
        if (out_ack_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o    = (state_q != F_IDLE);
  assign out_o.valid = (state_q == F_HOLD);
  assign out_o.page  = dvd_q;
endmodule

// ===== rtl/lpfc_fifo.sv =====
// Short queue of page numbers between the divider and the frame search.
// Depends on lpfc_pkg.
`timescale 1ns / 1ps
module lpfc_fifo import lpfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lpfc_page_t in_i,
  output logic       in_ack_o,
  output lpfc_page_t out_o,
  input  logic       out_ack_i
);
  localparam int unsigned PTR_W = $clog2(QDEPTH);

  logic [ADDR_W-1:0] mem_q [QDEPTH];
  logic [PTR_W-1:0]  wp_q, rp_q;
  logic [PTR_W:0]    cnt_q;
  logic              wr, rd;

  assign in_ack_o = in_i.valid && (cnt_q != (PTR_W+1)'(QDEPTH));
  assign wr       = in_ack_o;
  assign rd       = out_ack_i && (cnt_q != '0);
  assign out_o.valid = (cnt_q != '0);
  assign out_o.page  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_i.page;
  end
endmodule

// ===== rtl/lpfc_lru.sv =====
// Back end: walks the active frames one per cycle looking for a hit, the
// first empty frame and the oldest stamp, then updates the frame and fault
// count. Holds the result register. Depends on lpfc_pkg.
`timescale 1ns / 1ps
module lpfc_lru import lpfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lpfc_page_t  in_i,
  output logic        in_ack_o,
  input  logic [4:0]  num_frames_i,
  output lpfc_res_t   res_o,
  output logic        res_valid_o,
  input  logic        res_ack_i
);
  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SCAN  = 3'b010,
    B_WRITE = 3'b100
  } bstate_e;

  bstate_e             state_q, state_d;
  logic [ADDR_W-1:0]   tag_q   [FRAMES];
  logic [STAMP_W-1:0]  stamp_q [FRAMES];
  logic [FRAMES-1:0]   valid_q;
  logic [STAMP_W-1:0]  clock_q;
  logic [TOTAL_W-1:0]  faults_q;

  logic [ADDR_W-1:0]   page_q;
  logic [FIDX_W-1:0]   idx_q, last_q, hit_idx_q, emp_idx_q, min_idx_q;
  logic                hit_q, emp_q;
  logic [STAMP_W-1:0]  min_q;
  logic                out_v_q;
  lpfc_res_t           res_q;

  logic [FCNT_W-1:0]   n_act;
  logic                start, cur_hit, cur_emp;
  logic [FIDX_W-1:0]   slot;
  logic [STAMP_W-1:0]  clk_nx;
  logic [TOTAL_W-1:0]  faults_nx;

  // clamp frame count to 1..FRAMES
  always_comb begin
    if (num_frames_i == '0) n_act = FCNT_W'(1);
    else if (32'(num_frames_i) > FRAMES) n_act = FCNT_W'(FRAMES);
    else n_act = FCNT_W'(num_frames_i);
  end

  assign start    = (state_q == B_IDLE) && in_i.valid && !out_v_q;
  assign in_ack_o = start;
  assign cur_hit  = valid_q[idx_q] && (tag_q[idx_q] == page_q);
  assign cur_emp  = !valid_q[idx_q];
  assign slot     = hit_q ? hit_idx_q : (emp_q ? emp_idx_q : min_idx_q);
  assign clk_nx   = clock_q + 1'b1;
  assign faults_nx = (faults_q == '1) ? faults_q : faults_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (start) state_d = B_SCAN;
      B_SCAN:  if (cur_hit || idx_q == last_q) state_d = B_WRITE;
      B_WRITE: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      valid_q  <= '0;
      clock_q  <= '0;
      faults_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_WRITE) begin
        clock_q <= clk_nx;
        out_v_q <= 1'b1;
        if (!hit_q) begin
          faults_q      <= faults_nx;
          valid_q[slot] <= 1'b1;
        end
      end else if (res_ack_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // scan bookkeeping, frame store and result word
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        page_q    <= in_i.page;
        idx_q     <= '0;
        last_q    <= FIDX_W'(n_act - 1'b1);
        hit_q     <= 1'b0;
        emp_q     <= 1'b0;
        hit_idx_q <= '0;
        emp_idx_q <= '0;
        min_idx_q <= '0;
        min_q     <= '0;
      end
      B_SCAN: begin
        idx_q <= idx_q + 1'b1;
        if (cur_hit) begin
          hit_q     <= 1'b1;
          hit_idx_q <= idx_q;
        end
        if (cur_emp && !emp_q) begin
          emp_q     <= 1'b1;
          emp_idx_q <= idx_q;
        end
        // ties keep the lower index
        if (idx_q == '0 || stamp_q[idx_q] < min_q) begin
          min_q     <= stamp_q[idx_q];
          min_idx_q <= idx_q;
        end
      end
      B_WRITE: begin
        stamp_q[slot] <= clk_nx;
        if (!hit_q) tag_q[slot] <= page_q;
        res_q.fault <= !hit_q;
        res_q.frame <= slot;
        res_q.page  <= page_q;
        res_q.total <= hit_q ? faults_q : faults_nx;
      end
      default: ;
    endcase
  end

  assign res_o       = res_q;
  assign res_valid_o = out_v_q;
endmodule

// ===== rtl/lru_page_fault_counter_unit.sv =====
// Top level of the LRU page fault counter: config registers, divider front,
// page queue and LRU frame back end. Depends on lpfc_pkg, lpfc_div, lpfc_fifo and lpfc_lru.
//
//  channel   handshake         word
//  input     push / full       ref_address_i
//  result    pop / empty       fault_o, frame_used_o, page_number_o, fault_total_o
//  config    cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// Each word is first divided, then goes through the frame scan and update.
// Divider and frame scan overlap through a two-word queue, so sustained
// throughput is set by the one-bit-per-cycle divider, which takes no new
// address until its last page number has been taken by the queue.
// Reset clears valid bits, reference clock and fault count at once; no sweep.
// A waiting result blocks the frame scan; the divider keeps accepting until the queue is full and its word is held.
`timescale 1ns / 1ps
module lru_page_fault_counter_unit import lpfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [ADDR_W-1:0] ref_address_i,
  output logic              empty,
  input  logic              pop,
  output logic              fault_o,
  output logic [FIDX_W-1:0] frame_used_o,
  output logic [ADDR_W-1:0] page_number_o,
  output logic [TOTAL_W-1:0] fault_total_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i
);
  logic [4:0]        num_frames_q;
  logic [ADDR_W-1:0] page_bytes_q;
  logic              div_busy, q_in_ack, q_out_ack, res_v;
  lpfc_page_t        div_out, q_out;
  lpfc_res_t         res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= NUM_FRAMES_RST;
      page_bytes_q <= PAGE_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_FRAMES: num_frames_q <= cfg_wdata_i[4:0];
        REG_PAGE_BYTES: page_bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lpfc_div u_div (
    .clk_i, .rst_ni,
    .start_i      (push && !full),
    .addr_i       (ref_address_i),
    .page_bytes_i (page_bytes_q),
    .busy_o       (div_busy),
    .out_o        (div_out),
    .out_ack_i    (q_in_ack)
  );

  lpfc_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_i      (div_out),
    .in_ack_o  (q_in_ack),
    .out_o     (q_out),
    .out_ack_i (q_out_ack)
  );

  lpfc_lru u_lru (
    .clk_i, .rst_ni,
    .in_i         (q_out),
    .in_ack_o     (q_out_ack),
    .num_frames_i (num_frames_q),
    .res_o        (res),
    .res_valid_o  (res_v),
    .res_ack_i    (pop && res_v)
  );

  assign full          = div_busy;
  assign empty         = !res_v;
  assign fault_o       = res.fault;
  assign frame_used_o  = res.frame;
  assign page_number_o = res.page;
  assign fault_total_o = res.total;
endmodule

// ===== rtl/lpfc_checker.sv =====
// Port-level checks for the LRU page fault counter, bound to the top level.
// Depends on lpfc_pkg and lru_page_fault_counter_unit.
`timescale 1ns / 1ps
module lpfc_checker import lpfc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               fault_o,
  input logic [FIDX_W-1:0]  frame_used_o,
  input logic [ADDR_W-1:0]  page_number_o,
  input logic [TOTAL_W-1:0] fault_total_o
);
  // divider is busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full) else $error("full low after accept");

  // a waiting result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(fault_o) && $stable(frame_used_o)
      && $stable(page_number_o) && $stable(fault_total_o))
    else $error("result changed while waiting");

  // a fault result always carries a nonzero total
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && fault_o |-> fault_total_o != '0) else $error("fault with zero total");

  // single result register: a new result must pass through the scan and write states first
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty |=> empty) else $error("result reappeared at once");
endmodule

bind lru_page_fault_counter_unit lpfc_checker u_lpfc_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop,
  .fault_o, .frame_used_o, .page_number_o, .fault_total_o
);

// ===== tb/sv/lru_page_fault_counter_unit_test.sv =====
// Testbench for lru_page_fault_counter_unit: directed table, then random phases
// of reference traces under several frame counts and page sizes. Depends on lpfc_pkg
// and the unit. Each popped word is checked against a typed want or the in-bench LRU model.
`timescale 1ns / 1ps
module lru_page_fault_counter_unit_test;
  import lpfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_e;

  // One line of the directed table
  typedef struct {
    row_kind_e         kind;
    logic              idx;
    logic [ADDR_W-1:0] val;
    bit                typed;
    lpfc_res_t         want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [ADDR_W-1:0]  ref_address_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               fault_o;
  logic [FIDX_W-1:0]  frame_used_o;
  logic [ADDR_W-1:0]  page_number_o;
  logic [TOTAL_W-1:0] fault_total_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata_i = '0;

  lru_page_fault_counter_unit uut (.*);

  always #1 clk_i = ~clk_i;

  // Frame model state
  logic [4:0]         mdl_num_frames;
  logic [ADDR_W-1:0]  mdl_page_bytes;
  logic [ADDR_W-1:0]  mdl_tags   [FRAMES];
  logic               mdl_valid  [FRAMES];
  logic [STAMP_W-1:0] mdl_stamps [FRAMES];
  logic [STAMP_W-1:0] mdl_clock;
  logic [TOTAL_W-1:0] mdl_faults;

  lpfc_res_t pending_words[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        words_popped = 0;

  function automatic int active_frames();
    int n;
    n = mdl_num_frames;
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] eff_page_bytes();
    return (mdl_page_bytes == '0) ? ADDR_W'(1) : mdl_page_bytes;
  endfunction

  // LRU lookup / fill for one reference; updates model state
  function automatic lpfc_res_t lru_lookup(logic [ADDR_W-1:0] addr);
    lpfc_res_t         r;
    logic [ADDR_W-1:0] page;
    int                n;
    int                slot;
    bit                hit;
    bit                found_empty;
    page = addr / eff_page_bytes();
    n = active_frames();
    slot = 0;
    hit = 0;
    found_empty = 0;
    mdl_clock = mdl_clock + 1;
    for (int i = 0; i < n; i++) begin
      if (!hit && mdl_valid[i] && mdl_tags[i] == page) begin
        slot = i;
        hit = 1;
      end
    end
    if (hit) begin
      mdl_stamps[slot] = mdl_clock;
    end else begin
      if (mdl_faults != '1) mdl_faults = mdl_faults + 1;
      for (int i = 0; i < n; i++) begin
        if (!found_empty && !mdl_valid[i]) begin
          slot = i;
          found_empty = 1;
        end
      end
      if (!found_empty) begin
        slot = 0;
        for (int i = 1; i < n; i++)
          if (mdl_stamps[i] < mdl_stamps[slot]) slot = i;
      end
      mdl_tags[slot]   = page;
      mdl_valid[slot]  = 1'b1;
      mdl_stamps[slot] = mdl_clock;
    end
    r.fault = !hit;
    r.frame = FIDX_W'(slot);
    r.page  = page;
    r.total = mdl_faults;
    return r;
  endfunction

  // Config write: only while idle
  task automatic write_reg(logic idx, logic [ADDR_W-1:0] val);
    wait (pending_words.size() == 0);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    if (idx == REG_NUM_FRAMES) mdl_num_frames = val[4:0];
    else mdl_page_bytes = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one reference word; typed expectation overrides model output
  bit send_idle = 1;
  task automatic send_ref(logic [ADDR_W-1:0] addr, bit typed, lpfc_res_t want);
    int        gap;
    lpfc_res_t r;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    ref_address_i = addr;
    do @(posedge clk_i); while (full);
    r = lru_lookup(addr);
    pending_words.push_back(typed ? want : r);
    @(negedge clk_i);
    // word taken; stop offering until the next one is ready
    push = 1'b0;
  endtask

  // Random address: mostly from a small working set so hits and evictions occur
  function automatic logic [ADDR_W-1:0] draw_addr();
    int unsigned sel;
    longint      a;
    longint      pb;
    sel = $urandom_range(0, 99);
    pb = eff_page_bytes();
    if (sel < 75) begin
      a = longint'($urandom_range(0, active_frames() + 3)) * pb + $urandom_range(0, 65535) % pb;
      if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF - $urandom_range(0, 255);
      return ADDR_W'(a);
    end else if (sel < 92) begin
      return ADDR_W'($urandom());
    end else begin
      return sel[0] ? '1 : '0;
    end
  endfunction

  // Receiver: random pops, one long hold-off to back up the input
  initial begin
    int        gap;
    lpfc_res_t want;
    bit        recv_idle;
    recv_idle = 1;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_idle = !recv_idle;
      gap = recv_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: page %0h", page_number_o);
      end else begin
        want = pending_words.pop_front();
        if (fault_o !== want.fault || frame_used_o !== want.frame ||
            page_number_o !== want.page || fault_total_o !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp f=%0b fr=%0d pg=%0h tot=%0d got f=%0b fr=%0d pg=%0h tot=%0d",
                     want.fault, want.frame, want.page, want.total,
                     fault_o, frame_used_o, page_number_o, fault_total_o);
        end
      end
      words_popped++;
      @(negedge clk_i);
      if (words_popped == 150) begin
        pop = 1'b0;
        repeat (400) @(negedge clk_i);
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("lru_page_fault_counter_unit test failed");
        $finish;
      end
    end
  end

  stim_row_t dir_table[$];
  lpfc_res_t no_want;

  function automatic lpfc_res_t res(bit f, int fr, logic [ADDR_W-1:0] pg, int tot);
    lpfc_res_t r;
    r.fault = f;
    r.frame = FIDX_W'(fr);
    r.page = pg;
    r.total = TOTAL_W'(tot);
    return r;
  endfunction

  initial begin
    logic [4:0]        nf_set [7] = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd31, 5'd17, 5'd8};
    logic [ADDR_W-1:0] pb_set [7] = '{31'd4096, 31'd1, 31'd0, 31'd256, 31'h7FFF_FFFF,
                                      31'd64, 31'd3};
    no_want = '0;
    // After reset: 16 frames, 4096-byte pages
    dir_table = '{
      '{ROW_REF, 1'b0, 31'h0,          1, res(1, 0, 31'h0, 1)},
      '{ROW_REF, 1'b0, 31'h0,          1, res(0, 0, 31'h0, 1)},
      '{ROW_REF, 1'b0, 31'h7FFF_FFFF,  1, res(1, 1, 31'h7FFFF, 2)},
      '{ROW_REF, 1'b0, 31'd4096,       1, res(1, 2, 31'h1, 3)},
      '{ROW_REF, 1'b0, 31'd4095,       1, res(0, 0, 31'h0, 3)},
      '{ROW_CFG, REG_NUM_FRAMES, 31'd1, 0, no_want},
      '{ROW_REF, 1'b0, 31'd8192,       0, no_want},
      '{ROW_CFG, REG_NUM_FRAMES, 31'd0, 0, no_want},
      '{ROW_REF, 1'b0, 31'd8192,       0, no_want},
      '{ROW_CFG, REG_PAGE_BYTES, 31'd0, 0, no_want},
      '{ROW_REF, 1'b0, 31'd5,          0, no_want},
      '{ROW_CFG, REG_NUM_FRAMES, 31'd31, 0, no_want},
      '{ROW_REF, 1'b0, 31'd4096,       0, no_want},
      '{ROW_CFG, REG_PAGE_BYTES, 31'h7FFF_FFFF, 0, no_want},
      '{ROW_REF, 1'b0, 31'h7FFF_FFFF,  0, no_want},
      '{ROW_REF, 1'b0, 31'h0,          0, no_want},
      '{ROW_CFG, REG_NUM_FRAMES, 31'd2, 0, no_want},
      '{ROW_CFG, REG_PAGE_BYTES, 31'd1, 0, no_want},
      '{ROW_REF, 1'b0, 31'd9,          0, no_want},
      '{ROW_REF, 1'b0, 31'd10,         0, no_want},
      '{ROW_REF, 1'b0, 31'd11,         0, no_want}
    };
    mdl_num_frames = NUM_FRAMES_RST;
    mdl_page_bytes = PAGE_BYTES_RST;
    for (int i = 0; i < FRAMES; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_tags[i] = '0;
      mdl_stamps[i] = '0;
    end
    mdl_clock = '0;
    mdl_faults = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) write_reg(dir_table[i].idx, dir_table[i].val);
      else send_ref(dir_table[i].val, dir_table[i].typed, dir_table[i].want);
    end

    // Random phases over several settings
    for (int ph = 0; ph < 7; ph++) begin
      push = 1'b0;
      write_reg(REG_NUM_FRAMES, ADDR_W'(nf_set[ph]));
      write_reg(REG_PAGE_BYTES, pb_set[ph]);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
        send_ref(draw_addr(), 0, no_want);
      end
    end
    push = 1'b0;

    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("lru_page_fault_counter_unit test passed");
    end else begin
      $display("lru_page_fault_counter_unit test failed");
    end
    $finish;
  end
endmodule
